FILE: rtl/s9enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 encoder package
// Shared constants, selector layout tables and item types of the encoder.
// ----------------------------------------------------------------------------
package s9enc_pkg;

  localparam int unsigned S9_SLOTS    = 28;  // values held before a word is forced
  localparam int unsigned S9_IN_W     = 32;  // width of an incoming value
  localparam int unsigned S9_VAL_W    = 28;  // width of a stored value
  localparam int unsigned S9_CNT_W    = 5;   // holds 0..S9_SLOTS
  localparam int unsigned S9_NUM_SEL  = 9;
  localparam int unsigned S9_SEL_W    = 4;   // selector field in the packed word
  localparam int unsigned S9_WORD_W   = 32;
  localparam int unsigned S9_QUEUE_DEPTH = 2;

  localparam logic [S9_VAL_W-1:0] S9_VAL_MAX = 28'hFFF_FFFF;

  // Bits per value and values per word for each selector, narrowest first.
  localparam int unsigned S9_SEL_BITS [S9_NUM_SEL] = '{1, 2, 3, 4, 5, 7, 9, 14, 28};
  localparam int unsigned S9_SEL_CNT  [S9_NUM_SEL] = '{28, 14, 9, 7, 5, 4, 3, 2, 1};

  // One buffered value with its narrowest fitting selector.
  typedef struct packed {
    logic [S9_VAL_W-1:0] value;
    logic                clamp;
    logic [S9_SEL_W-1:0] cls;
  } s9_slot_t;

  // Request as it travels through the queue.
  typedef struct packed {
    s9_slot_t slot;
    logic     last;
  } s9_item_t;

  // Handshake and payload from the queue to the packer.
  typedef struct packed {
    logic     valid;
    s9_item_t item;
  } s9_q_t;

  // One packed result.
  typedef struct packed {
    logic                 clamped;
    logic                 last_word;
    logic [S9_CNT_W-1:0]  count;
    logic [S9_WORD_W-1:0] word;
  } s9_word_t;

endpackage

FILE: rtl/s9enc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 encoder front end
// Clamps an incoming value to 28 bits and finds its narrowest selector.
// ----------------------------------------------------------------------------
module s9enc_front
  import s9enc_pkg::*;
(
  input  logic [S9_IN_W-1:0] value,
  input  logic               is_last,
  output s9_item_t           item
);

  logic                clamp;
  logic [S9_VAL_W-1:0] val28;
  logic [S9_SEL_W-1:0] cls;

  assign clamp = (value[S9_IN_W-1:S9_VAL_W] != '0);
  assign val28 = clamp ? S9_VAL_MAX : value[S9_VAL_W-1:0];

  // Search from the widest layout down so the narrowest that fits wins.
  always_comb begin
    cls = S9_SEL_W'(S9_NUM_SEL - 1);
    for (int s = S9_NUM_SEL - 1; s >= 0; s--) begin
      if ((val28 >> S9_SEL_BITS[s]) == '0) begin
        cls = S9_SEL_W'(s);
      end
    end
  end

  assign item.slot.value = val28;
  assign item.slot.clamp = clamp;
  assign item.slot.cls   = cls;
  assign item.last       = is_last;

endmodule

FILE: rtl/s9enc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 encoder request queue
// Small show-ahead FIFO between the front end and the packer.
// ----------------------------------------------------------------------------
module s9enc_queue
  import s9enc_pkg::*;
#(
  parameter int unsigned DEPTH = S9_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  s9_item_t wr_item,
  output logic     full,
  input  logic     rd_en,
  output s9_q_t    rd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  s9_item_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;

  assign full     = (fill_r == CW'(DEPTH));
  assign rd.valid = (fill_r != '0);
  assign rd.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/s9enc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 encoder packer
// Buffers up to 28 values and packs 32-bit words into an output register.
// ----------------------------------------------------------------------------
module s9enc_back
  import s9enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  s9_q_t    q,
  output logic     q_pop,
  output logic     res_valid,
  input  logic     res_ready,
  output s9_word_t res
);

  s9_slot_t               ent_r [S9_SLOTS];
  s9_slot_t               ent_nxt [S9_SLOTS];
  logic [S9_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                   flush_r, flush_nxt;
  logic                   res_valid_r, res_valid_nxt;
  s9_word_t               res_r;

  logic [S9_NUM_SEL-1:0]  fit;
  logic [S9_SEL_W-1:0]    sel;
  logic [S9_CNT_W-1:0]    n_c [S9_NUM_SEL];
  logic [S9_WORD_W-1:0]   word_c [S9_NUM_SEL];
  logic [S9_NUM_SEL-1:0]  clamp_c;
  logic [S9_CNT_W-1:0]    n_sel;
  logic [S9_CNT_W-1:0]    cnt_left;
  logic                   slot_free;
  logic                   do_emit;
  logic                   do_pop;

  // Fit check and candidate words for all nine layouts in parallel.
  always_comb begin
    for (int s = 0; s < S9_NUM_SEL; s++) begin
      fit[s]     = 1'b1;
      clamp_c[s] = 1'b0;
      word_c[s]  = S9_WORD_W'(s);
      n_c[s]     = (S9_CNT_W'(S9_SEL_CNT[s]) < cnt_r) ? S9_CNT_W'(S9_SEL_CNT[s]) : cnt_r;
      for (int k = 0; k < S9_SLOTS; k++) begin
        if ((k < S9_SEL_CNT[s]) && (S9_CNT_W'(k) < cnt_r)) begin
          if (ent_r[k].cls > S9_SEL_W'(s)) begin
            fit[s] = 1'b0;
          end
          clamp_c[s] = clamp_c[s] | ent_r[k].clamp;
          word_c[s]  = word_c[s] |
                       (S9_WORD_W'(ent_r[k].value) << (S9_SEL_W + k * S9_SEL_BITS[s]));
        end
      end
    end
  end

  always_comb begin
    sel = S9_SEL_W'(S9_NUM_SEL - 1);
    for (int s = S9_NUM_SEL - 1; s >= 0; s--) begin
      if (fit[s]) begin
        sel = S9_SEL_W'(s);
      end
    end
  end

  assign n_sel     = n_c[sel];
  assign cnt_left  = cnt_r - n_sel;
  assign slot_free = !res_valid_r || res_ready;
  assign do_emit   = slot_free && (flush_r ? (cnt_r != '0) : (cnt_r == S9_CNT_W'(S9_SLOTS)));
  assign do_pop    = q.valid && !flush_r && (cnt_r < S9_CNT_W'(S9_SLOTS));
  assign q_pop     = do_pop;

  always_comb begin
    for (int i = 0; i < S9_SLOTS; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    cnt_nxt       = cnt_r;
    flush_nxt     = flush_r;
    res_valid_nxt = res_valid_r && !res_ready;
    if (do_pop) begin
      ent_nxt[cnt_r] = q.item.slot;
      cnt_nxt        = cnt_r + 1'b1;
      flush_nxt      = q.item.last;
    end else if (do_emit) begin
      for (int s = 0; s < S9_NUM_SEL; s++) begin
        if (sel == S9_SEL_W'(s)) begin
          for (int i = 0; i < S9_SLOTS; i++) begin
            if (i + S9_SEL_CNT[s] < S9_SLOTS) begin
              ent_nxt[i] = ent_r[i + S9_SEL_CNT[s]];
            end
          end
        end
      end
      cnt_nxt       = cnt_left;
      res_valid_nxt = 1'b1;
      if (cnt_left == '0) begin
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flush_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      flush_r     <= flush_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < S9_SLOTS; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
    if (do_emit) begin
      res_r.word      <= word_c[sel];
      res_r.count     <= n_sel;
      res_r.last_word <= flush_r && (cnt_left == '0);
      res_r.clamped   <= clamp_c[sel];
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/simple9_word_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 word encoder
// Packs a stream of unsigned integers into 32-bit Simple-9 words.
// ----------------------------------------------------------------------------
// Path: requests go through the queue into the packer buffer, words leave from
// the output register. Throughput: one request per cycle while the queue has
// room; the single packer takes no values for a forced word (28 pending) or flush.
// Reset (rst_n low, synchronous) empties the queue, the buffer and the output
// register; buffered value storage itself is not cleared.
// ----------------------------------------------------------------------------
module simple9_word_encoder
  import s9enc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = S9_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_last: ends the stream and flushes the buffer
  // Packed words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] word, [36:32] count_packed, [39:37] zero
  output logic        out_tlast,  // last_word: final word of a flush
  output logic        out_tuser   // clamped: a packed value was wider than 28 bits
);

  s9_item_t item_in;
  s9_q_t    q;
  logic     q_full;
  logic     q_pop;
  logic     in_acc;
  s9_word_t res;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && !q_full;

  // The front end clamps each value and tags it with the narrowest
  // selector that holds it, so the packer only compares small codes.
  s9enc_front u_front (
    .value   (in_tdata),
    .is_last (in_tlast),
    .item    (item_in)
  );

  // The queue lets the input side keep accepting while the packer is
  // busy emitting a word or waits on the output side.
  s9enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_item (item_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd      (q)
  );

  // The packer appends values one per cycle while it holds fewer than 28 and is
  // not flushing. At 28 pending it emits one word; after a request marked last
  // it emits words, one each cycle the output is ready, until the buffer is empty.
  s9enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {3'b000, res.count, res.word};
  assign out_tlast = res.last_word;
  assign out_tuser = res.clamped;

endmodule

FILE: sim/s9_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 word checker
// Watches both streams of the encoder. It keeps its own copy of the pending
// value buffer and works out the packed words that each accepted request
// must cause. It compares every word that leaves the encoder with the oldest
// word still owed.
// ----------------------------------------------------------------------------
module s9_word_checker
  import s9enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser,
  output int unsigned mismatches,
  output int unsigned words_owed
);

  localparam int unsigned SLOTS = 28;

  logic [27:0] held_val [SLOTS];
  logic        held_clamp [SLOTS];
  int unsigned held_n;
  s9_word_t    owed_words [$];
  s9_word_t    want;

  initial begin
    mismatches = 0;
    words_owed = 0;
    held_n     = 0;
  end

  function automatic int unsigned field_bits(input int unsigned sel);
    case (sel)
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 5;
      5: return 7;
      6: return 9;
      7: return 14;
      default: return 28;
    endcase
  endfunction

  // Builds one word from the front of the buffer and drops what it packed.
  function automatic void pack_front_word(input logic flushing);
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    int unsigned bits;
    logic        fits;
    logic [31:0] mask;
    logic [31:0] w;
    logic        any_clamp;
    s9_word_t    res;

    n    = 0;
    bits = 28;
    mask = 32'h0FFF_FFFF;
    for (sel = 0; sel < 9; sel++) begin
      bits = field_bits(sel);
      mask = (32'd1 << bits) - 32'd1;
      n    = (SLOTS / bits < held_n) ? SLOTS / bits : held_n;
      fits = 1'b1;
      for (k = 0; k < n; k++) begin
        if ({4'b0, held_val[k]} > mask) fits = 1'b0;
      end
      if (fits) break;
    end
    w         = sel;
    any_clamp = 1'b0;
    for (k = 0; k < n; k++) begin
      w = w | (({4'b0, held_val[k]} & mask) << (4 + k * bits));
      if (held_clamp[k]) any_clamp = 1'b1;
    end
    res.word      = w;
    res.count     = n[4:0];
    res.last_word = flushing && (n == held_n);
    res.clamped   = any_clamp;
    owed_words.push_back(res);
    for (k = 0; k + n < held_n; k++) begin
      held_val[k]   = held_val[k + n];
      held_clamp[k] = held_clamp[k + n];
    end
    held_n = held_n - n;
  endfunction

  function automatic void take_value(input logic [31:0] v, input logic ends_stream);
    if (held_n >= SLOTS) pack_front_word(1'b0);
    held_clamp[held_n] = (v > 32'h0FFF_FFFF);
    held_val[held_n]   = (v > 32'h0FFF_FFFF) ? 28'hFFF_FFFF : v[27:0];
    held_n++;
    if (ends_stream) begin
      while (held_n > 0) pack_front_word(1'b1);
    end else if (held_n >= SLOTS) begin
      pack_front_word(1'b0);
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [39:0] got,
                               input logic [39:0] exp_val);
    $display("%0t: word mismatch in %s: got %h, want %h", $realtime, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) take_value(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (owed_words.size() == 0) begin
          flag_mismatch("unexpected word", out_tdata, 40'h0);
        end else begin
          want = owed_words.pop_front();
          if (out_tdata[31:0] != want.word)
            flag_mismatch("word", out_tdata[31:0], want.word);
          if (out_tdata[36:32] != want.count)
            flag_mismatch("count_packed", out_tdata[36:32], want.count);
          if (out_tdata[39:37] != 3'b000)
            flag_mismatch("padding", out_tdata[39:37], 40'h0);
          if (out_tlast != want.last_word)
            flag_mismatch("last_word", out_tlast, want.last_word);
          if (out_tuser != want.clamped)
            flag_mismatch("clamped", out_tuser, want.clamped);
        end
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

FILE: sim/simple9_word_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple-9 word encoder testbench
// Feeds integer streams of mixed widths into the encoder under changing
// amounts of sender idling and receiver back-pressure, including one long
// receiver hold-off. A separate checker predicts and compares every word.
// ----------------------------------------------------------------------------
module simple9_word_encoder_tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'h0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  int unsigned mismatches;
  int unsigned words_owed;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned sent          = 0;
  int unsigned tb_cycles     = 0;

  always #10 clk = ~clk;

  simple9_word_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  s9_word_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .words_owed (words_owed)
  );

  // Receiver: a pending hold-off wins over the random stall rate.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_tready = ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Guard against a hung encoder.
  always @(posedge clk) begin
    tb_cycles++;
    if (tb_cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one request and returns at the falling edge after it was taken.
  // The valid stays high into the next request unless an idle gap is drawn.
  task automatic offer_value(input logic [31:0] v, input logic ends_stream);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = v;
    in_tlast  = ends_stream;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  // A value of at most the given number of bits, with its top bit often set.
  function automatic logic [31:0] value_of_bits(input int unsigned bits);
    logic [31:0] v;
    v = $urandom;
    if (bits == 0) return 32'h0;
    if (bits < 32) v = v & ((32'd1 << bits) - 32'd1);
    if ($urandom_range(0, 1) == 1) v = v | (32'd1 << (bits - 1));
    return v;
  endfunction

  // Field widths of the nine layouts, plus values too wide to store.
  function automatic int unsigned pick_width();
    case ($urandom_range(0, 10))
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4;
      4: return 5;
      5: return 7;
      6: return 9;
      7: return 14;
      8: return 28;
      9: return 32;
      default: return $urandom_range(0, 32);
    endcase
  endfunction

  // A well-formed stream: values mostly narrow enough for one layout, with
  // an odd full-width value mixed in, closed by a flush.
  task automatic offer_stream(input int unsigned len);
    int unsigned wmax;
    int unsigned i;
    logic [31:0] v;
    wmax = pick_width();
    for (i = 0; i < len; i++) begin
      v = value_of_bits($urandom_range(0, wmax));
      if ($urandom_range(0, 9) == 0) v = $urandom;
      offer_value(v, i == len - 1);
    end
  endtask

  // Changes the idling rates away from the falling edge the receiver uses.
  task automatic set_rates(input int unsigned idle_pct, input int unsigned stall_pct);
    in_tvalid = 1'b0;
    @(posedge clk);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned quota);
    int unsigned start;
    set_rates(idle_pct, stall_pct);
    start = sent;
    while (sent - start < quota) begin
      // About one stream in four is long enough to force a word before
      // its flush.
      if ($urandom_range(0, 3) == 0) offer_stream($urandom_range(29, 60));
      else offer_stream($urandom_range(1, 28));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero, values at and beyond the 28-bit limit, the largest
    // value of each narrower width, and a wide value ahead of small ones.
    offer_value(32'h0000_0000, 1'b1);
    offer_value(32'hFFFF_FFFF, 1'b1);
    offer_value(32'h0FFF_FFFF, 1'b1);
    offer_value(32'h1000_0000, 1'b1);
    offer_value(32'd1, 1'b0);
    offer_value(32'd3, 1'b0);
    offer_value(32'd7, 1'b0);
    offer_value(32'd15, 1'b1);
    offer_value(32'd31, 1'b0);
    offer_value(32'd127, 1'b0);
    offer_value(32'd511, 1'b0);
    offer_value(32'd16383, 1'b1);
    offer_value(32'd16384, 1'b0);
    offer_value(32'd1, 1'b1);
    offer_value(32'h8000_0000, 1'b0);
    offer_value(32'd0, 1'b0);
    offer_value(32'd1, 1'b1);

    // Random streams under three idling mixes.
    run_phase(0, 0, 40);
    run_phase(69, 0, 40);
    run_phase(0, 69, 40);

    // Long receiver hold-off while the sender keeps offering, so the encoder
    // fills up and drops in_tready.
    set_rates(0, 0);
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    offer_stream(45);

    run_phase(28, 28, 40);

    in_tvalid = 1'b0;
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/s9enc_pkg.sv
rtl/s9enc_front.sv
rtl/s9enc_queue.sv
rtl/s9enc_back.sv
rtl/simple9_word_encoder.sv
sim/s9_word_checker.sv
sim/simple9_word_encoder_tb.sv
